// ----- rtl/itoa_pkg.sv -----
// Shared constants and helpers for the integer to ASCII formatter.
// Used by itoa_dd_step and integer_to_ascii_formatter; no dependencies.
`default_nettype none

package itoa_pkg;

    // Default width of the formatted word
    localparam int VALUE_BITS_DEF = 64;

    // Format mode codes
    typedef enum logic [1:0] {
        T_REQ_SDEC = 2'd0,
        T_REQ_UDEC = 2'd1,
        T_REQ_HEX  = 2'd2,
        T_REQ_PTR  = 2'd3
    } t_req_type;

    // Character codes
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_A     = 8'h61;

    // Map one digit (0..15) to its lowercase ASCII code
    function automatic logic [7:0] hex_ascii(input logic [3:0] dig);
        logic [7:0] res;
        if (dig < 4'd10) begin
            res = CHAR_ZERO + {4'd0, dig};
        end else begin
            res = CHAR_A + {4'd0, dig} - 8'd10;
        end
        return res;
    endfunction

    // Add-3 correction of one BCD digit ahead of a doubling
    function automatic logic [3:0] bcd_adjust(input logic [3:0] dig);
        logic [3:0] res;
        if (dig >= 4'd5) begin
            res = dig + 4'd3;
        end else begin
            res = dig;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/integer_to_ascii_formatter.sv -----
// Flow: a decimal word is shifted one bit at a time through the shared double-dabble step,
// then a negative word gets a '-' sign, leading zeros are skipped, one step picks the first
// digit and the digits are emitted. Hex skips the conversion and the leading zeros;
// pointer emits a 0x prefix and then every hex digit, leading zeros included.
// Characters are registered from the sequencer state; the last one shows in the first
// idle cycle, where the next word can be taken. A new word is taken only while idle; no stall.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops o_valid.
`default_nettype none

module integer_to_ascii_formatter #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire logic [1:0]            i_req_type,
    output logic                       o_valid,
    output logic [7:0]                 o_ascii_char,
    output logic                       o_is_last
);
    import itoa_pkg::*;

    // Decimal digits for VALUE_BITS bits, hex digits, and digit register width
    localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int HDIG = (VALUE_BITS + 3) / 4;
    localparam int DW   = 4 * NDIG;
    localparam int HB   = 4 * HDIG;
    localparam int BW   = $clog2(VALUE_BITS + 1);
    localparam int CW   = $clog2(NDIG + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_PFX0,
        S_PFX1,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic [VALUE_BITS-1:0] r_mag;
    logic [DW-1:0]         r_dig;
    logic [BW-1:0]         r_bits;
    logic [CW-1:0]         r_cnt;
    logic                  r_neg;

    logic                  accept;
    logic                  is_neg;
    logic [VALUE_BITS-1:0] mag;
    logic [HB-1:0]         hex_ext;
    logic [DW-1:0]         n_bcd;
    logic [3:0]            top_dig;
    t_req_type             req;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign req     = t_req_type'(i_req_type);
    assign is_neg  = (req == T_REQ_SDEC) && i_value[VALUE_BITS-1];
    assign mag     = is_neg ? (~i_value + VALUE_BITS'(1)) : i_value;
    assign hex_ext = HB'(i_value);
    assign top_dig = r_dig[DW-1 -: 4];

    // Shared conversion step
    itoa_dd_step #(
        .NDIG (NDIG)
    ) u_dd_step (
        .i_bcd (r_dig),
        .i_bit (r_mag[VALUE_BITS-1]),
        .o_bcd (n_bcd)
    );

    // Sequencer with registered character output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            o_is_last <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            o_is_last <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mag  <= mag;
                        r_neg  <= is_neg;
                        r_bits <= BW'(VALUE_BITS);
                        unique case (req)
                            T_REQ_SDEC, T_REQ_UDEC: begin
                                r_dig   <= '0;
                                r_cnt   <= CW'(NDIG);
                                r_state <= S_CONV;
                            end
                            T_REQ_HEX: begin
                                r_dig   <= DW'(hex_ext) << (DW - HB);
                                r_cnt   <= CW'(HDIG);
                                r_state <= S_SKIP;
                            end
                            T_REQ_PTR: begin
                                r_dig   <= DW'(hex_ext) << (DW - HB);
                                r_cnt   <= CW'(HDIG);
                                r_state <= S_PFX0;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CONV: begin
                    // Advance one bit through the BCD accumulator
                    r_dig  <= n_bcd;
                    r_mag  <= r_mag << 1;
                    r_bits <= r_bits - BW'(1);
                    if (r_bits == BW'(1)) begin
                        r_state <= r_neg ? S_PFX0 : S_SKIP;
                    end
                end
                S_PFX0: begin
                    // Sign for negative decimal, else the 0 of the 0x prefix
                    o_valid      <= 1'b1;
                    o_ascii_char <= r_neg ? CHAR_MINUS : CHAR_ZERO;
                    r_state      <= r_neg ? S_SKIP : S_PFX1;
                end
                S_PFX1: begin
                    o_valid      <= 1'b1;
                    o_ascii_char <= CHAR_X;
                    r_state      <= S_EMIT;
                end
                S_SKIP: begin
                    // Drop leading zeros, keep at least one digit
                    if (top_dig == 4'd0 && r_cnt != CW'(1)) begin
                        r_dig <= r_dig << 4;
                        r_cnt <= r_cnt - CW'(1);
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    o_valid      <= 1'b1;
                    o_ascii_char <= hex_ascii(top_dig);
                    o_is_last    <= (r_cnt == CW'(1));
                    r_dig        <= r_dig << 4;
                    r_cnt        <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A taken word makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    // Every character comes out of an active conversion
    a_valid_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("character without a word in progress");

    // The final character coincides with the return to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_last) |-> !busy)
        else $error("last character while still busy");

    // The digit count never runs out while emitting
    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_cnt != '0))
        else $error("emit with no digits left");

    // is_last only rides on a valid character
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_is_last |-> o_valid)
        else $error("is_last without a valid character");

endmodule

`default_nettype wire

// ----- rtl/itoa_dd_step.sv -----
// One double-dabble step: correct every BCD digit, then shift in one binary bit.
// Depends on itoa_pkg for the digit correction.
`default_nettype none

module itoa_dd_step #(
    parameter int NDIG = 20
) (
    input  wire logic [4*NDIG-1:0] i_bcd,
    input  wire logic              i_bit,
    output logic      [4*NDIG-1:0] o_bcd
);
    import itoa_pkg::*;

    logic [4*NDIG-1:0] adj;

    // Correct all digits in parallel
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            adj[4*k +: 4] = bcd_adjust(i_bcd[4*k +: 4]);
        end
    end

    // Double and bring in the next binary bit
    assign o_bcd = {adj[4*NDIG-2:0], i_bit};

endmodule

`default_nettype wire
